// ----- hdl/rhc_pkg.sv -----
package rhc_pkg;

    // Field widths fixed by the pixel and result formats
    localparam int CH_W    = 8;
    localparam int HUE_W   = 15;
    localparam int SAT_W   = 16;
    localparam int LIT_W   = 9;
    localparam int LIT_MAX = 510;

    // Hue sector, picked by the largest channel
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Classified pixel, front to back
    typedef struct packed {
        logic              grey;
        sector_t           sector;
        logic              diff_neg;
        logic [CH_W-1:0]   diff_mag;
        logic [CH_W-1:0]   chroma;
        logic [CH_W-1:0]   den;
        logic [LIT_W-1:0]  sum;
    } cls_t;

    // Finished result
    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  sat;
        logic [LIT_W-1:0]  lit;
    } res_t;

endpackage

// ----- hdl/rgb_to_hsl_converter.sv -----
// Channel   Direction  Handshake          Fields
// input     in         push / full        red[7:0] green[7:0] blue[7:0]
// result    out        empty / pop        hue_angle[14:0] saturation_frac[15:0]
//                                         lightness_sum[8:0]
//
// One item enters per clock and one result leaves per clock, sustained while pop is held.
// The divide pipeline has N quotient stages, where N is the larger of
// SAT_BITS and clog2(60 * 2^HUE_FRAC_BITS + 1): 16 quotient stages at the defaults.
// The divide pipeline retires one quotient bit per stage for hue and saturation.
// Reset (rst_n low, asynchronous) empties both queues and every stage.
// A held-off pop stalls the divide pipeline as a whole; full rises once the
// classify stage is occupied and the queue between front and back is full.
module rgb_to_hsl_converter #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_BITS      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        pop,
    output logic        empty,
    output logic [14:0] hue_angle,
    output logic [15:0] saturation_frac,
    output logic [8:0]  lightness_sum
);

    localparam int CLS_W = $bits(rhc_pkg::cls_t);
    localparam int RES_W = $bits(rhc_pkg::res_t);

    logic               fq_push;
    rhc_pkg::cls_t      fq_item;
    logic               mq_full;
    logic               mq_empty;
    logic [CLS_W-1:0]   mq_dout;
    rhc_pkg::cls_t      mq_item;
    logic               mq_pop;
    logic               bk_push;
    rhc_pkg::res_t      bk_item;
    logic               oq_full;
    logic [RES_W-1:0]   oq_dout;
    rhc_pkg::res_t      oq_item;

    // Classify incoming pixels
    rhc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .red    (red),
        .green  (green),
        .blue   (blue),
        .q_push (fq_push),
        .q_item (fq_item),
        .q_full (mq_full)
    );

    // Decouple front from back
    rhc_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (fq_item),
        .full  (mq_full),
        .pop   (mq_pop),
        .dout  (mq_dout),
        .empty (mq_empty)
    );

    assign mq_item = rhc_pkg::cls_t'(mq_dout);

    // Divide and compose results
    rhc_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SAT_BITS      (SAT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!mq_empty),
        .in_item  (mq_item),
        .in_pop   (mq_pop),
        .out_push (bk_push),
        .out_item (bk_item),
        .out_full (oq_full)
    );

    // Hold finished results for the consumer
    rhc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_push),
        .din   (bk_item),
        .full  (oq_full),
        .pop   (pop),
        .dout  (oq_dout),
        .empty (empty)
    );

    assign oq_item         = rhc_pkg::res_t'(oq_dout);
    assign hue_angle       = oq_item.hue;
    assign saturation_frac = oq_item.sat;
    assign lightness_sum   = oq_item.lit;

endmodule

// ----- hdl/rhc_fifo.sv -----
module rhc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Store an item at the write pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and track the fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/rhc_front.sv -----
module rhc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output logic                q_push,
    output rhc_pkg::cls_t       q_item,
    input  logic                q_full
);

    logic                           valid_reg;
    logic                           valid_next;
    rhc_pkg::cls_t                  item_reg;
    rhc_pkg::cls_t                  item_next;
    logic                           accept;
    logic                           advance;
    logic [rhc_pkg::CH_W-1:0]       mx;
    logic [rhc_pkg::CH_W-1:0]       mn;
    logic [rhc_pkg::CH_W-1:0]       op_a;
    logic [rhc_pkg::CH_W-1:0]       op_b;
    logic [rhc_pkg::CH_W:0]         diff;
    logic [rhc_pkg::CH_W:0]         diff_abs;
    logic [rhc_pkg::LIT_W-1:0]      sum;
    logic [rhc_pkg::LIT_W-1:0]      inv;
    logic [rhc_pkg::LIT_W-1:0]      den_w;
    rhc_pkg::sector_t               sector;

    assign advance = !valid_reg || !q_full;
    assign full    = !advance;
    assign accept  = push && advance;
    assign q_push  = valid_reg && !q_full;
    assign q_item  = item_reg;

    // Pick the sector, red first on ties, then green
    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sector = rhc_pkg::SECT_RED;
        end
        else if (green >= blue)
        begin
            sector = rhc_pkg::SECT_GREEN;
        end
        else
        begin
            sector = rhc_pkg::SECT_BLUE;
        end
    end

    // Find max, min and the in-sector channel difference
    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;

        case (sector)
            rhc_pkg::SECT_RED:
            begin
                op_a = green;
                op_b = blue;
            end
            rhc_pkg::SECT_GREEN:
            begin
                op_a = blue;
                op_b = red;
            end
            rhc_pkg::SECT_BLUE:
            begin
                op_a = red;
                op_b = green;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase

        diff     = {1'b0, op_a} - {1'b0, op_b};
        diff_abs = diff[rhc_pkg::CH_W] ? (~diff + 1'b1) : diff;
        sum      = {1'b0, mx} + {1'b0, mn};
        inv      = rhc_pkg::LIT_W'(rhc_pkg::LIT_MAX) - sum;
        den_w    = (inv < sum) ? inv : sum;
    end

    // Pack the classified item
    always_comb
    begin
        item_next.grey     = (mx == mn);
        item_next.sector   = sector;
        item_next.diff_neg = diff[rhc_pkg::CH_W];
        item_next.diff_mag = diff_abs[rhc_pkg::CH_W-1:0];
        item_next.chroma   = mx - mn;
        item_next.den      = den_w[rhc_pkg::CH_W-1:0];
        item_next.sum      = sum;
    end

    // Hold the valid flag until the queue takes the item
    always_comb
    begin
        if (advance)
        begin
            valid_next = push;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hdl/rhc_back.sv -----
module rhc_back #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_BITS      = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rhc_pkg::cls_t    in_item,
    output logic             in_pop,
    output logic             out_push,
    output rhc_pkg::res_t    out_item,
    input  logic             out_full
);

    localparam int CHW      = rhc_pkg::CH_W;
    localparam int HUE_UNIT = 60 << HUE_FRAC_BITS;
    localparam int CIRCLE   = 360 << HUE_FRAC_BITS;
    localparam int HQW      = $clog2(HUE_UNIT + 1);
    localparam int N        = (HQW > SAT_BITS) ? HQW : SAT_BITS;
    localparam int W        = N + CHW;
    localparam int HW0      = $clog2(CIRCLE) + 2;
    localparam int HW       = (HW0 > rhc_pkg::HUE_W + 1) ? HW0 : rhc_pkg::HUE_W + 1;
    localparam int SW       = (N > rhc_pkg::SAT_W) ? N : rhc_pkg::SAT_W;
    localparam logic [N-1:0] SAT_FULL = N'((64'd1 << SAT_BITS) - 64'd1);

    localparam logic signed [HW-1:0] CIRCLE_S = HW'(CIRCLE);
    localparam logic signed [HW-1:0] OFS_G    = HW'(2 * HUE_UNIT);
    localparam logic signed [HW-1:0] OFS_B    = HW'(4 * HUE_UNIT);

    // One restoring division step: bring down a numerator bit, shift in a quotient bit
    function automatic logic [CHW+N-1:0] div_step(
        input logic [CHW-1:0] rem,
        input logic [N-1:0]   work,
        input logic [CHW-1:0] d
    );
        logic [CHW:0]   t;
        logic [CHW:0]   t_sub;
        logic           ge;
        logic [CHW-1:0] rem_n;
        t     = {rem, work[N-1]};
        ge    = (t >= {1'b0, d});
        t_sub = t - {1'b0, d};
        rem_n = ge ? t_sub[CHW-1:0] : t[CHW-1:0];
        return {rem_n, work[N-2:0], ge};
    endfunction

    logic                       v_reg      [0:N];
    logic [CHW-1:0]             rem_h_reg  [0:N];
    logic [N-1:0]               work_h_reg [0:N];
    logic [CHW-1:0]             rem_s_reg  [0:N];
    logic [N-1:0]               work_s_reg [0:N];
    logic [CHW-1:0]             chroma_reg [0:N];
    logic [CHW-1:0]             den_reg    [0:N];
    logic                       grey_reg   [0:N];
    logic                       neg_reg    [0:N];
    rhc_pkg::sector_t           sector_reg [0:N];
    logic [rhc_pkg::LIT_W-1:0]  sum_reg    [0:N];

    logic                       advance;
    logic [W-1:0]               hue_num;
    logic [W-1:0]               sat_num;
    logic [N-1:0]               q_h;
    logic [N-1:0]               q_s;
    logic [HW-1:0]              q_mag;
    logic signed [HW-1:0]       q_signed;
    logic signed [HW-1:0]       hue_full;
    logic [SW-1:0]              sat_ext;

    // The whole pipe moves unless the last item is blocked at the output queue
    assign advance  = !v_reg[N] || !out_full;
    assign in_pop   = advance && in_valid;
    assign out_push = v_reg[N] && !out_full;

    // Form both numerators
    assign hue_num = W'(HUE_UNIT) * W'(in_item.diff_mag);
    assign sat_num = (W'(in_item.chroma) << SAT_BITS) - W'(in_item.chroma);

    // Load the entry stage from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_h_reg[0]  <= hue_num[W-1:N];
            work_h_reg[0] <= hue_num[N-1:0];
            rem_s_reg[0]  <= sat_num[W-1:N];
            work_s_reg[0] <= sat_num[N-1:0];
            chroma_reg[0] <= in_item.chroma;
            den_reg[0]    <= in_item.den;
            grey_reg[0]   <= in_item.grey;
            neg_reg[0]    <= in_item.diff_neg;
            sector_reg[0] <= in_item.sector;
            sum_reg[0]    <= in_item.sum;
        end
    end

    // Divide stages, one quotient bit per stage for hue and saturation
    for (genvar k = 1; k <= N; k++)
    begin : g_div
        logic [CHW+N-1:0] step_h;
        logic [CHW+N-1:0] step_s;

        assign step_h = div_step(rem_h_reg[k-1], work_h_reg[k-1], chroma_reg[k-1]);
        assign step_s = div_step(rem_s_reg[k-1], work_s_reg[k-1], den_reg[k-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_h_reg[k]  <= step_h[CHW+N-1:N];
                work_h_reg[k] <= step_h[N-1:0];
                rem_s_reg[k]  <= step_s[CHW+N-1:N];
                work_s_reg[k] <= step_s[N-1:0];
                chroma_reg[k] <= chroma_reg[k-1];
                den_reg[k]    <= den_reg[k-1];
                grey_reg[k]   <= grey_reg[k-1];
                neg_reg[k]    <= neg_reg[k-1];
                sector_reg[k] <= sector_reg[k-1];
                sum_reg[k]    <= sum_reg[k-1];
            end
        end
    end

    assign q_h = work_h_reg[N];
    assign q_s = work_s_reg[N];

    // Apply sign and sector offset, wrap negative hue by a full circle
    always_comb
    begin
        q_mag    = HW'(q_h);
        q_signed = neg_reg[N] ? -$signed(q_mag) : $signed(q_mag);
        case (sector_reg[N])
            rhc_pkg::SECT_RED:
            begin
                hue_full = (q_signed < 0) ? q_signed + CIRCLE_S : q_signed;
            end
            rhc_pkg::SECT_GREEN:
            begin
                hue_full = q_signed + OFS_G;
            end
            rhc_pkg::SECT_BLUE:
            begin
                hue_full = q_signed + OFS_B;
            end
            default:
            begin
                hue_full = '0;
            end
        endcase
    end

    // Grey pixels carry zero hue and zero saturation
    always_comb
    begin
        sat_ext = SW'(q_s);
        if (grey_reg[N])
        begin
            out_item.hue = '0;
            out_item.sat = '0;
        end
        else
        begin
            out_item.hue = hue_full[rhc_pkg::HUE_W-1:0];
            out_item.sat = sat_ext[rhc_pkg::SAT_W-1:0];
        end
        out_item.lit = sum_reg[N];
    end

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop |-> in_valid)
        else $error("back pulled an item from an empty queue");

    a_entry_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance && v_reg[0] |=> v_reg[1])
        else $error("item lost between entry and first divide stage");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> v_reg[N])
        else $error("blocked result dropped from last stage");

    a_hue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[N] && !grey_reg[N] |-> (q_h <= N'(HUE_UNIT)))
        else $error("hue quotient beyond one sector");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[N] && !grey_reg[N] |-> (q_s <= SAT_FULL))
        else $error("saturation quotient beyond full scale");

endmodule

// ----- dv/hsl_result_checker.sv -----
`timescale 1ns / 1ps

module hsl_result_checker #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_BITS      = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [rhc_pkg::CH_W-1:0]   red,
    input  logic [rhc_pkg::CH_W-1:0]   green,
    input  logic [rhc_pkg::CH_W-1:0]   blue,
    input  logic                       pop,
    input  logic                       empty,
    input  logic [rhc_pkg::HUE_W-1:0]  hue_angle,
    input  logic [rhc_pkg::SAT_W-1:0]  saturation_frac,
    input  logic [rhc_pkg::LIT_W-1:0]  lightness_sum,
    output int                         error_count,
    output int                         in_flight,
    output int                         pixels_in,
    output int                         results_out
);

    localparam int     HUE_UNIT   = 60 << HUE_FRAC_BITS;
    localparam int     HUE_CIRCLE = 360 << HUE_FRAC_BITS;
    localparam longint SAT_FULL   = (longint'(1) << SAT_BITS) - 1;

    // Results still owed by the block, oldest first
    rhc_pkg::res_t expected_hsl_q[$];

    initial
    begin
        error_count = 0;
        in_flight   = 0;
        pixels_in   = 0;
        results_out = 0;
    end

    // Convert one pixel to its expected hue, saturation and lightness
    function automatic rhc_pkg::res_t convert_pixel(input logic [rhc_pkg::CH_W-1:0] r,
                                                    input logic [rhc_pkg::CH_W-1:0] g,
                                                    input logic [rhc_pkg::CH_W-1:0] b);
        int               rv;
        int               gv;
        int               bv;
        int               mx;
        int               mn;
        int               chroma;
        int               sum;
        int               den;
        int               diff;
        int               offset;
        int               hue;
        longint           sat;
        rhc_pkg::sector_t sector;
        rhc_pkg::res_t    res;

        rv = int'(r);
        gv = int'(g);
        bv = int'(b);
        mx = rv;
        mn = rv;
        if (gv > mx) mx = gv;
        if (bv > mx) mx = bv;
        if (gv < mn) mn = gv;
        if (bv < mn) mn = bv;
        chroma = mx - mn;
        sum    = mx + mn;

        // Largest channel picks the sector, red first on ties, then green
        if (rv >= gv && rv >= bv)
            sector = rhc_pkg::SECT_RED;
        else if (gv >= bv)
            sector = rhc_pkg::SECT_GREEN;
        else
            sector = rhc_pkg::SECT_BLUE;

        case (sector)
            rhc_pkg::SECT_GREEN:
            begin
                diff   = bv - rv;
                offset = 2 * HUE_UNIT;
            end
            rhc_pkg::SECT_BLUE:
            begin
                diff   = rv - gv;
                offset = 4 * HUE_UNIT;
            end
            default:
            begin
                diff   = gv - bv;
                offset = 0;
            end
        endcase

        // Grey pixels keep zero hue and zero saturation
        hue = 0;
        sat = 0;
        if (chroma != 0)
        begin
            // Signed division truncates toward zero; wrap a negative red hue
            hue = (HUE_UNIT * diff) / chroma + offset;
            if (hue < 0)
                hue += HUE_CIRCLE;
            den = (rhc_pkg::LIT_MAX - sum < sum) ? rhc_pkg::LIT_MAX - sum : sum;
            if (den > 0)
                sat = (longint'(chroma) * SAT_FULL) / longint'(den);
        end

        res.hue = hue[rhc_pkg::HUE_W-1:0];
        res.sat = sat[rhc_pkg::SAT_W-1:0];
        res.lit = sum[rhc_pkg::LIT_W-1:0];
        return res;
    endfunction

    // Compare each popped result against the oldest expectation, then log new items
    always @(posedge clk)
    begin
        rhc_pkg::res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                results_out++;
                if (expected_hsl_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: hue %0d sat %0d lit %0d",
                             $time, hue_angle, saturation_frac, lightness_sum);
                    error_count++;
                end
                else
                begin
                    want = expected_hsl_q.pop_front();
                    if (hue_angle !== want.hue)
                    begin
                        $display("%0t: hue_angle expected %0d, got %0d",
                                 $time, want.hue, hue_angle);
                        error_count++;
                    end
                    if (saturation_frac !== want.sat)
                    begin
                        $display("%0t: saturation_frac expected %0d, got %0d",
                                 $time, want.sat, saturation_frac);
                        error_count++;
                    end
                    if (lightness_sum !== want.lit)
                    begin
                        $display("%0t: lightness_sum expected %0d, got %0d",
                                 $time, want.lit, lightness_sum);
                        error_count++;
                    end
                end
            end
            if (push && !full)
            begin
                expected_hsl_q.push_back(convert_pixel(red, green, blue));
                pixels_in++;
            end
            in_flight = expected_hsl_q.size();
        end
    end

endmodule

// ----- dv/tb_rgb_to_hsl_converter.sv -----
`timescale 1ns / 1ps

module tb_rgb_to_hsl_converter;

    // Cycles to wait after the last result
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASE_PIXELS = 430;

    logic                      clk   = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      push  = 1'b0;
    logic                      full;
    logic [rhc_pkg::CH_W-1:0]  red   = '0;
    logic [rhc_pkg::CH_W-1:0]  green = '0;
    logic [rhc_pkg::CH_W-1:0]  blue  = '0;
    logic                      pop   = 1'b0;
    logic                      empty;
    logic [rhc_pkg::HUE_W-1:0] hue_angle;
    logic [rhc_pkg::SAT_W-1:0] saturation_frac;
    logic [rhc_pkg::LIT_W-1:0] lightness_sum;

    int error_count;
    int in_flight;
    int pixels_in;
    int results_out;
    int send_idle_pct = 13;
    int recv_idle_pct = 45;

    rgb_to_hsl_converter i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .pop             (pop),
        .empty           (empty),
        .hue_angle       (hue_angle),
        .saturation_frac (saturation_frac),
        .lightness_sum   (lightness_sum)
    );

    hsl_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .pop             (pop),
        .empty           (empty),
        .hue_angle       (hue_angle),
        .saturation_frac (saturation_frac),
        .lightness_sum   (lightness_sum),
        .error_count     (error_count),
        .in_flight       (in_flight),
        .pixels_in       (pixels_in),
        .results_out     (results_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stall the result side at random, one decision per cycle
    initial
    begin
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one pixel after random idle cycles and hold it until accepted
    task automatic send_pixel(input logic [rhc_pkg::CH_W-1:0] r,
                              input logic [rhc_pkg::CH_W-1:0] g,
                              input logic [rhc_pkg::CH_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push  <= 1'b1;
        red   <= r;
        green <= g;
        blue  <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    // Hold off the input until every owed result has been popped
    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
    endtask

    // Mix of random pixels, greys, ties and edge values
    task automatic send_random_pixels(input int count);
        logic [rhc_pkg::CH_W-1:0] r;
        logic [rhc_pkg::CH_W-1:0] g;
        logic [rhc_pkg::CH_W-1:0] b;
        logic [rhc_pkg::CH_W-1:0] top_val;
        int                       kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(9);
            r = rhc_pkg::CH_W'($urandom);
            g = rhc_pkg::CH_W'($urandom);
            b = rhc_pkg::CH_W'($urandom);
            case (kind)
                5:
                begin
                    // grey pixel
                    g = r;
                    b = r;
                end
                6:
                begin
                    // two channels tie for the largest
                    top_val = rhc_pkg::CH_W'($urandom_range(255, 1));
                    case ($urandom_range(2))
                        0:
                        begin
                            r = top_val;
                            g = top_val;
                            b = rhc_pkg::CH_W'($urandom_range(top_val));
                        end
                        1:
                        begin
                            g = top_val;
                            b = top_val;
                            r = rhc_pkg::CH_W'($urandom_range(top_val));
                        end
                        default:
                        begin
                            r = top_val;
                            b = top_val;
                            g = rhc_pkg::CH_W'($urandom_range(top_val));
                        end
                    endcase
                end
                7:
                begin
                    // channels at or next to the range ends
                    r = ($urandom_range(1) ? 8'hFF : 8'h00) ^ rhc_pkg::CH_W'($urandom_range(1));
                    g = ($urandom_range(1) ? 8'hFF : 8'h00) ^ rhc_pkg::CH_W'($urandom_range(1));
                    b = ($urandom_range(1) ? 8'hFF : 8'h00) ^ rhc_pkg::CH_W'($urandom_range(1));
                end
                8:
                begin
                    // max plus min near the lightness midpoint
                    r = rhc_pkg::CH_W'($urandom_range(255, 120));
                    g = 8'd255 - r + rhc_pkg::CH_W'($urandom_range(2));
                    b = rhc_pkg::CH_W'($urandom_range(r)) | g;
                    if (b > r)
                        b = r;
                    if (b < g)
                        b = g;
                end
                9:
                begin
                    // nearly grey, small chroma
                    g = r ^ rhc_pkg::CH_W'($urandom_range(3));
                    b = r ^ rhc_pkg::CH_W'($urandom_range(3));
                end
                default:
                begin
                end
            endcase
            send_pixel(r, g, b);
        end
    endtask

    initial
    begin
        #200000;
        $display("tb_rgb_to_hsl_converter: done, errors");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corners: greys, primaries, ties, wrap and saturation edges
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd200, 8'd10,  8'd199);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd128, 8'd127, 8'd127);
        send_pixel(8'd127, 8'd128, 8'd0);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd10,  8'd200, 8'd30);
        send_pixel(8'd30,  8'd60,  8'd250);
        send_pixel(8'd170, 8'd85,  8'd255);
        drain_results();

        send_random_pixels(PHASE_PIXELS);
        drain_results();

        send_idle_pct = 45;
        recv_idle_pct = 13;
        send_random_pixels(PHASE_PIXELS);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_pixels(PHASE_PIXELS);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_rgb_to_hsl_converter: %0d pixels in, %0d results compared",
                 pixels_in, results_out);
        $display("tb_rgb_to_hsl_converter: greys, ties, hue wrap, edge values, three stall mixes");
        if (error_count == 0 && in_flight == 0)
            $display("tb_rgb_to_hsl_converter: done, clean");
        else
            $display("tb_rgb_to_hsl_converter: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/rhc_pkg.sv
hdl/rhc_fifo.sv
hdl/rhc_front.sv
hdl/rhc_back.sv
hdl/rgb_to_hsl_converter.sv
dv/hsl_result_checker.sv
dv/tb_rgb_to_hsl_converter.sv
